/* rtl/inode_block_allocator_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the inode block allocator
// Shared property forms; clk and rst_n are taken from the enclosing module.
// ---------------------------------------------------------------------------
`ifndef INODE_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define INODE_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define IBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define IBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/iba_pkg.sv */
// ---------------------------------------------------------------------------
// iba_pkg
// Field widths, request and status codes, and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package iba_pkg;

    localparam int REQT_W     = 2;
    localparam int NAME_W     = 64;
    localparam int NAME_BYTES = 8;
    localparam int SIZE_W     = 4;
    localparam int IDX_W      = 4;
    localparam int STAT_W     = 3;
    localparam int DBLK_W     = 7;

    localparam logic [REQT_W-1:0] REQ_CREATE = 2'd0;
    localparam logic [REQT_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQT_W-1:0] REQ_MAP    = 2'd2;
    localparam logic [REQT_W-1:0] REQ_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADSIZE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOINODE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd5;

    // block map control and status
    typedef struct packed {
        logic wr_en;
        logic wr_val;
    } bm_ctrl_t;

    typedef struct packed {
        logic init_done;
        logic rd_bit;
    } bm_stat_t;

    // clear every byte from the first zero byte on
    function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] n);
        logic [NAME_W-1:0] keep;
        logic              live;
        keep = '0;
        live = 1'b1;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (n[8*b +: 8] == 8'h00)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                keep[8*b +: 8] = n[8*b +: 8];
            end
        end
        return keep;
    endfunction

endpackage

`default_nettype wire

/* rtl/iba_if.sv */
// ---------------------------------------------------------------------------
// iba request / response interfaces
// valid/ready channels carrying one request or one result per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface iba_req_if import iba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQT_W-1:0] req_type;
    logic [NAME_W-1:0] file_name;
    logic [SIZE_W-1:0] size_blocks;
    logic [IDX_W-1:0]  block_index;

    modport source (output valid, output req_type, output file_name,
                    output size_blocks, output block_index, input ready);
    modport sink   (input valid, input req_type, input file_name,
                    input size_blocks, input block_index, output ready);
endinterface

interface iba_rsp_if import iba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [DBLK_W-1:0] disk_block;

    modport source (output valid, output status, output disk_block, input ready);
    modport sink   (input valid, input status, input disk_block, output ready);
endinterface

`default_nettype wire

/* rtl/inode_block_allocator_core.sv */
// ---------------------------------------------------------------------------
// inode_block_allocator_core
// Small file table with a free-block map: create, delete and block mapping.
// ---------------------------------------------------------------------------
// One request transaction in gives exactly one result transaction out. After
// reset the block map is swept once, and no request is taken until the sweep
// finishes. Requests are then worked one at a time by a small sequencer
// around one name comparator and the map/table memory ports. A create takes
// longer the higher the index of the first free inode and of the last block
// it allocates; a delete or a map takes longer the higher the index of the
// matching inode, and a delete also grows with the file size; a failing
// lookup walks every entry. The next request can be taken in the cycle after
// the load of the result register. The block map read port reads one bit per
// cycle; it and the entry scan set how long a request takes.
// The result sits in an output register, so a new request is taken while
// the previous result waits for the sink.
// ---------------------------------------------------------------------------
`default_nettype none

`include "inode_block_allocator_core_defines.svh"

module inode_block_allocator_core import iba_pkg::*; #(
    parameter int NUM_BLOCKS      = 128,
    parameter int NUM_ENTRIES     = 16,
    parameter int MAX_FILE_BLOCKS = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iba_req_if.sink    req,
    iba_rsp_if.source  rsp
);

    localparam int BA_W = $clog2(NUM_BLOCKS);
    localparam int FC_W = $clog2(NUM_BLOCKS + 1);
    localparam int E_W  = $clog2(NUM_ENTRIES);
    localparam int PTR_DEPTH = NUM_ENTRIES * MAX_FILE_BLOCKS;
    localparam int PA_W = (PTR_DEPTH > 1) ? $clog2(PTR_DEPTH) : 1;
    localparam int PX_W = E_W + 5;
    localparam int SZC_W = SIZE_W + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;  // create: size and space checks
    localparam logic [3:0] S_FINDE  = 4'd2;  // create: lowest free inode
    localparam logic [3:0] S_ALLOC  = 4'd3;  // create: walk map, take free blocks
    localparam logic [3:0] S_SCAN   = 4'd4;  // delete/map: name lookup
    localparam logic [3:0] S_FREE   = 4'd5;  // delete: release pointed blocks
    localparam logic [3:0] S_MAPRD  = 4'd6;  // map: read pointer
    localparam logic [3:0] S_MAPOUT = 4'd7;  // map: capture pointer
    localparam logic [3:0] S_DONE   = 4'd8;  // hand result to output register

    logic [3:0]            state_reg, state_next;
    logic [REQT_W-1:0]     rtype_reg, rtype_next;
    logic [NAME_W-1:0]     name_reg, name_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [E_W-1:0]        e_reg, e_next;
    logic [E_W-1:0]        erd_reg, erd_next;
    logic [E_W-1:0]        epend_reg, epend_next;
    logic                  pend_reg, pend_next;
    logic [BA_W-1:0]       b_reg, b_next;
    logic [BA_W-1:0]       bpend_reg, bpend_next;
    logic [SIZE_W-1:0]     i_reg, i_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [DBLK_W-1:0]     dblk_reg, dblk_next;
    logic [NUM_ENTRIES-1:0] used_reg, used_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0]     rsp_status_reg;
    logic [DBLK_W-1:0]     rsp_dblk_reg;

    // file table memories
    logic [NAME_W-1:0]     name_mem [NUM_ENTRIES];
    logic [SIZE_W-1:0]     size_mem [NUM_ENTRIES];
    logic [BA_W-1:0]       ptr_mem  [PTR_DEPTH];
    logic [NAME_W-1:0]     name_rd_reg;
    logic [SIZE_W-1:0]     size_rd_reg;
    logic [BA_W-1:0]       ptr_rd_reg;

    logic                  entry_we;
    logic                  ptr_we;
    logic [SIZE_W-1:0]     col;
    logic [PX_W-1:0]       ptr_full;
    logic [PA_W-1:0]       ptr_addr;

    logic                  req_fire;
    logic                  rsp_load;
    logic                  name_hit;

    bm_ctrl_t              bm_ctrl;
    bm_stat_t              bm_stat;
    logic [BA_W-1:0]       bm_rd_addr;
    logic [BA_W-1:0]       bm_wr_addr;
    logic [FC_W-1:0]       free_cnt;

    iba_bitmap #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_bitmap (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (bm_ctrl),
        .rd_addr  (bm_rd_addr),
        .wr_addr  (bm_wr_addr),
        .stat     (bm_stat),
        .free_cnt (free_cnt)
    );

    assign req.ready = (state_reg == S_IDLE) && bm_stat.init_done;
    assign req_fire  = req.valid && req.ready;
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    // pointer slot: entry row times row length plus column
    assign col      = (state_reg == S_MAPRD) ? idx_reg : i_reg;
    assign ptr_full = PX_W'(e_reg) * PX_W'(MAX_FILE_BLOCKS) + PX_W'(col);
    assign ptr_addr = ptr_full[PA_W-1:0];

    // the one comparator: stored name of the pending scan slot vs request
    assign name_hit = pend_reg && used_reg[epend_reg] && (name_rd_reg == name_reg);

    always_comb
    begin
        state_next  = state_reg;
        rtype_next  = rtype_reg;
        name_next   = name_reg;
        size_next   = size_reg;
        idx_next    = idx_reg;
        e_next      = e_reg;
        erd_next    = erd_reg;
        epend_next  = epend_reg;
        pend_next   = pend_reg;
        b_next      = b_reg;
        bpend_next  = bpend_reg;
        i_next      = i_reg;
        status_next = status_reg;
        dblk_next   = dblk_reg;
        used_next   = used_reg;
        entry_we    = 1'b0;
        ptr_we      = 1'b0;
        bm_ctrl     = '0;
        bm_rd_addr  = b_reg;
        bm_wr_addr  = (state_reg == S_FREE) ? ptr_rd_reg : bpend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    rtype_next  = req.req_type;
                    name_next   = canon_name(req.file_name);
                    size_next   = req.size_blocks;
                    idx_next    = req.block_index;
                    status_next = ST_OK;
                    dblk_next   = '0;
                    e_next      = '0;
                    erd_next    = '0;
                    pend_next   = 1'b0;
                    unique case (req.req_type)
                        REQ_CREATE: state_next = S_CHECK;
                        REQ_DELETE: state_next = S_SCAN;
                        REQ_MAP:    state_next = S_SCAN;
                        REQ_NOP:    state_next = S_DONE;
                    endcase
                end
            end

            S_CHECK:
            begin
                priority if (SZC_W'(size_reg) > SZC_W'(MAX_FILE_BLOCKS))
                begin
                    status_next = ST_BADSIZE;
                    state_next  = S_DONE;
                end
                else if (free_cnt < FC_W'(size_reg))
                begin
                    status_next = ST_NOSPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_FINDE;
                end
            end

            S_FINDE:
            begin
                priority if (!used_reg[e_reg])
                begin
                    // claim inode now; blocks follow
                    entry_we         = 1'b1;
                    used_next[e_reg] = 1'b1;
                    b_next           = '0;
                    pend_next        = 1'b0;
                    i_next           = '0;
                    state_next       = (size_reg == '0) ? S_DONE : S_ALLOC;
                end
                else if (e_reg == E_W'(NUM_ENTRIES - 1))
                begin
                    status_next = ST_NOINODE;
                    state_next  = S_DONE;
                end
                else
                begin
                    e_next = e_reg + 1'b1;
                end
            end

            S_ALLOC:
            begin
                // read one map bit per cycle; its data returns in the next cycle
                b_next     = b_reg + 1'b1;
                bpend_next = b_reg;
                pend_next  = 1'b1;
                if (pend_reg && !bm_stat.rd_bit)
                begin
                    bm_ctrl.wr_en  = 1'b1;
                    bm_ctrl.wr_val = 1'b1;
                    ptr_we         = 1'b1;
                    i_next         = i_reg + 1'b1;
                    if (i_reg == size_reg - SIZE_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                erd_next   = erd_reg + 1'b1;
                epend_next = erd_reg;
                pend_next  = 1'b1;
                priority if (name_hit)
                begin
                    e_next    = epend_reg;
                    size_next = size_rd_reg;
                    i_next    = '0;
                    pend_next = 1'b0;
                    if (rtype_reg == REQ_DELETE)
                    begin
                        state_next = S_FREE;
                    end
                    else if (idx_reg >= size_rd_reg)
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MAPRD;
                    end
                end
                else if (pend_reg && (epend_reg == E_W'(NUM_ENTRIES - 1)))
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_FREE:
            begin
                // pointer read at i, clear of its map bit in the cycle after
                if (i_reg < size_reg)
                begin
                    i_next    = i_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    bm_ctrl.wr_en  = 1'b1;
                    bm_ctrl.wr_val = 1'b0;
                end
                if ((i_reg == size_reg) && !pend_reg)
                begin
                    used_next[e_reg] = 1'b0;
                    state_next       = S_DONE;
                end
            end

            S_MAPRD:
            begin
                state_next = S_MAPOUT;
            end

            S_MAPOUT:
            begin
                dblk_next  = DBLK_W'(ptr_rd_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // file table memories, registered reads
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            name_mem[e_reg] <= name_reg;
            size_mem[e_reg] <= size_reg;
        end
        if (ptr_we)
        begin
            ptr_mem[ptr_addr] <= bpend_reg;
        end
        name_rd_reg <= name_mem[erd_reg];
        size_rd_reg <= size_mem[erd_reg];
        ptr_rd_reg  <= ptr_mem[ptr_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rtype_reg  <= rtype_next;
        name_reg   <= name_next;
        size_reg   <= size_next;
        idx_reg    <= idx_next;
        e_reg      <= e_next;
        erd_reg    <= erd_next;
        epend_reg  <= epend_next;
        b_reg      <= b_next;
        bpend_reg  <= bpend_next;
        i_reg      <= i_next;
        status_reg <= status_next;
        dblk_reg   <= dblk_next;
        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_dblk_reg   <= dblk_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.disk_block = rsp_dblk_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // sequencer drops ready as soon as a request transaction is taken
    `IBA_ASSERT_NEXT(a_busy_after_req, req_fire, !req.ready, "ready held after request")
    // a result only appears out of the handoff state
    `IBA_ASSERT_SAME(a_rsp_from_done, $rose(rsp.valid), $past(state_reg == S_DONE), "stray result")
    // double free or double allocation would push the count out of range
    `IBA_ASSERT_SAME(a_free_bound, bm_stat.init_done, free_cnt <= FC_W'(NUM_BLOCKS - 1), "free count overflow")
    // a block number comes back only with a good status
    `IBA_ASSERT_SAME(a_dblk_ok, rsp.valid && (rsp.disk_block != '0), rsp.status == ST_OK, "block with error")

endmodule

`default_nettype wire

/* rtl/iba_bitmap.sv */
// ---------------------------------------------------------------------------
// iba_bitmap
// Disk block used-bit map: one-bit memory, clearing sweep after reset,
// registered read, one write port and a running free-block count.
// ---------------------------------------------------------------------------
`default_nettype none

module iba_bitmap import iba_pkg::*; #(
    parameter int NUM_BLOCKS = 128
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bm_ctrl_t                          ctrl,
    input  wire logic [$clog2(NUM_BLOCKS)-1:0]     rd_addr,
    input  wire logic [$clog2(NUM_BLOCKS)-1:0]     wr_addr,
    output bm_stat_t                               stat,
    output logic [$clog2(NUM_BLOCKS+1)-1:0]        free_cnt
);

    localparam int BA_W = $clog2(NUM_BLOCKS);
    localparam int FC_W = $clog2(NUM_BLOCKS + 1);

    logic            map_mem [NUM_BLOCKS];
    logic            rd_bit_reg;
    logic            init_done_reg;
    logic [BA_W-1:0] clr_addr_reg;
    logic [FC_W-1:0] free_cnt_reg;

    // sweep: block 0 holds metadata and starts used
    always_ff @(posedge clk)
    begin
        if (!init_done_reg)
        begin
            map_mem[clr_addr_reg] <= (clr_addr_reg == '0);
        end
        else if (ctrl.wr_en)
        begin
            map_mem[wr_addr] <= ctrl.wr_val;
        end
        rd_bit_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_done_reg <= 1'b0;
            clr_addr_reg  <= '0;
            free_cnt_reg  <= FC_W'(NUM_BLOCKS - 1);
        end
        else
        begin
            if (!init_done_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == BA_W'(NUM_BLOCKS - 1))
                begin
                    init_done_reg <= 1'b1;
                end
            end
            else if (ctrl.wr_en)
            begin
                free_cnt_reg <= ctrl.wr_val ? free_cnt_reg - 1'b1 : free_cnt_reg + 1'b1;
            end
        end
    end

    assign stat.init_done = init_done_reg;
    assign stat.rd_bit    = rd_bit_reg;
    assign free_cnt       = free_cnt_reg;

endmodule

`default_nettype wire

/* tb/sv/inode_block_allocator_core_tb.sv */
// ---------------------------------------------------------------------------
// inode_block_allocator_core_tb
// Self-checking bench: a directed table of file-table requests, then about two
// thousand random requests under four idle/stall mixes and one long output
// hold-off. Every result is checked field by field against a hand-typed answer
// or a behavioral model of the free-block map and the inode table.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module inode_block_allocator_core_tb import iba_pkg::*; ();

    // Same geometry as the defaults of the block; passed down explicitly.
    localparam int NUM_BLOCKS      = 128;
    localparam int NUM_ENTRIES     = 16;
    localparam int MAX_FILE_BLOCKS = 8;

    // Slowest single request (create scanning every inode and every block).
    localparam int SLOWEST_REQUEST = NUM_ENTRIES + NUM_BLOCKS + 4;
    localparam int SETTLE_CYCLES   = 2 * SLOWEST_REQUEST;
    localparam int HOLD_OFF_CYCLES = 500;
    // Quiet stretch allowed: reset sweep, hold-off, slowest request, margin.
    localparam int WATCHDOG_LIMIT  = 4 * (NUM_BLOCKS + HOLD_OFF_CYCLES + SLOWEST_REQUEST);

    localparam int PHASES         = 4;
    localparam int PHASE_ITEMS    = 490;
    localparam int PRESSURE_ITEMS = 40;
    localparam int NAME_POOL      = 12;
    localparam int DIRECTED_ROWS  = 25;

    typedef struct packed {
        logic [REQT_W-1:0] req_type;
        logic [NAME_W-1:0] file_name;
        logic [SIZE_W-1:0] size_blocks;
        logic [IDX_W-1:0]  block_index;
    } file_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DBLK_W-1:0] disk_block;
    } alloc_result_t;

    // One row of the directed table: the request, and where the answer is
    // obvious, the answer typed in by hand.
    typedef struct packed {
        file_req_t     rq;
        logic          typed;
        alloc_result_t want;
    } stim_row_t;

    typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} traffic_mix_e;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    // Directed names. A junk name carries garbage after its terminating zero
    // byte and must behave exactly like its clean form.
    localparam logic [NAME_W-1:0] NAME_A          = 64'h0000_0000_0000_0061;
    localparam logic [NAME_W-1:0] NAME_B          = 64'h0000_0000_0000_0062;
    localparam logic [NAME_W-1:0] NAME_B_JUNK     = 64'hAB00_CD00_0000_0062;
    localparam logic [NAME_W-1:0] NAME_FULL       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [NAME_W-1:0] NAME_EMPTY      = 64'h0000_0000_0000_0000;
    localparam logic [NAME_W-1:0] NAME_EMPTY_JUNK = 64'h1234_5678_9ABC_DE00;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    iba_req_if req_ch ();
    iba_rsp_if rsp_ch ();

    inode_block_allocator_core #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .NUM_ENTRIES     (NUM_ENTRIES),
        .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // -----------------------------------------------------------------------
    // Clock and reset
    // -----------------------------------------------------------------------
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // Behavioral copy of the file table
    // -----------------------------------------------------------------------
    logic              disk_used    [NUM_BLOCKS];
    logic              inode_live   [NUM_ENTRIES];
    logic [NAME_W-1:0] inode_name   [NUM_ENTRIES];
    logic [SIZE_W-1:0] inode_blocks [NUM_ENTRIES];
    logic [DBLK_W-1:0] inode_ptr    [NUM_ENTRIES][MAX_FILE_BLOCKS];

    // Results still owed by the block, oldest first.
    alloc_result_t awaited_results [$];

    // Stimulus knobs, shared with the response-side process.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_pending  = 1'b0;

    int fail_count = 0;
    int req_count    [4];
    int status_seen  [8];

    // Random names come from a small pool so that creates, deletes and maps
    // keep hitting the same files; lengths run from empty to all eight bytes.
    logic [NAME_W-1:0] name_pool [NAME_POOL];
    int                name_len  [NAME_POOL];

    // Applies one request to the model state and returns its result.
    // Names compare as strings: every byte from the first zero byte on is
    // dropped. A lookup always lands on the lowest live inode of that name.
    function automatic alloc_result_t file_table_result(input file_req_t rq);
        alloc_result_t     res;
        logic [NAME_W-1:0] nm;
        logic              live;
        int                hit;
        int                free_slot;
        int                free_blocks;
        int                blk;
        int                i;
        res  = '0;
        nm   = '0;
        live = 1'b1;
        for (i = 0; i < NAME_BYTES; i++)
        begin
            if (rq.file_name[8*i +: 8] == 8'h00)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                nm[8*i +: 8] = rq.file_name[8*i +: 8];
            end
        end
        hit       = NUM_ENTRIES;
        free_slot = NUM_ENTRIES;
        for (i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (inode_live[i] && inode_name[i] == nm)
            begin
                hit = i;
            end
            if (!inode_live[i])
            begin
                free_slot = i;
            end
        end
        free_blocks = 0;
        for (i = 0; i < NUM_BLOCKS; i++)
        begin
            if (!disk_used[i])
            begin
                free_blocks++;
            end
        end
        case (rq.req_type)
            REQ_CREATE:
            begin
                // size first, then space, then a free inode
                if (rq.size_blocks > MAX_FILE_BLOCKS)
                begin
                    res.status = ST_BADSIZE;
                end
                else if (free_blocks < rq.size_blocks)
                begin
                    res.status = ST_NOSPACE;
                end
                else if (free_slot == NUM_ENTRIES)
                begin
                    res.status = ST_NOINODE;
                end
                else
                begin
                    inode_live[free_slot]   = 1'b1;
                    inode_name[free_slot]   = nm;
                    inode_blocks[free_slot] = rq.size_blocks;
                    blk = 0;
                    for (i = 0; i < rq.size_blocks; i++)
                    begin
                        while (disk_used[blk])
                        begin
                            blk++;
                        end
                        disk_used[blk]         = 1'b1;
                        inode_ptr[free_slot][i] = DBLK_W'(blk);
                    end
                end
            end
            REQ_DELETE:
            begin
                if (hit == NUM_ENTRIES)
                begin
                    res.status = ST_NOTFOUND;
                end
                else
                begin
                    for (i = 0; i < inode_blocks[hit]; i++)
                    begin
                        disk_used[inode_ptr[hit][i]] = 1'b0;
                    end
                    inode_live[hit] = 1'b0;
                end
            end
            REQ_MAP:
            begin
                if (hit == NUM_ENTRIES)
                begin
                    res.status = ST_NOTFOUND;
                end
                else if (rq.block_index >= inode_blocks[hit])
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    res.disk_block = inode_ptr[hit][rq.block_index];
                end
            end
            default:
            begin
                // unused code: no state change, all-zero result
            end
        endcase
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Random request generation
    // -----------------------------------------------------------------------
    // FILL piles up large files until inodes or blocks run out, CHURN mixes
    // everything, DRAIN mostly deletes so that FILL has room again.
    function automatic file_req_t random_request(input traffic_mix_e mix);
        file_req_t rq;
        int        p_create;
        int        p_delete;
        int        p_map;
        int        roll;
        int        k;
        int        b;
        case (mix)
            MIX_FILL:  begin p_create = 70; p_delete = 5;  p_map = 20; end
            MIX_CHURN: begin p_create = 35; p_delete = 30; p_map = 30; end
            default:   begin p_create = 10; p_delete = 55; p_map = 30; end
        endcase
        roll = $urandom_range(99);
        if (roll < p_create)
        begin
            rq.req_type = REQ_CREATE;
        end
        else if (roll < p_create + p_delete)
        begin
            rq.req_type = REQ_DELETE;
        end
        else if (roll < p_create + p_delete + p_map)
        begin
            rq.req_type = REQ_MAP;
        end
        else
        begin
            rq.req_type = REQ_NOP;
        end

        // Name: mostly from the pool, sometimes with junk past the
        // terminator; a few fully random ones that miss.
        if ($urandom_range(99) < 15)
        begin
            rq.file_name = {$urandom, $urandom};
        end
        else
        begin
            k = $urandom_range(NAME_POOL - 1);
            rq.file_name = name_pool[k];
            if (name_len[k] < NAME_BYTES && $urandom_range(1) == 1)
            begin
                for (b = name_len[k] + 1; b < NAME_BYTES; b++)
                begin
                    rq.file_name[8*b +: 8] = 8'($urandom_range(255));
                end
            end
        end

        // Size only matters on create; elsewhere it is just noise.
        rq.size_blocks = SIZE_W'($urandom_range(15));
        if (rq.req_type == REQ_CREATE)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
            begin
                rq.size_blocks = SIZE_W'($urandom_range(15, MAX_FILE_BLOCKS + 1));
            end
            else if (mix == MIX_FILL && roll < 82)
            begin
                rq.size_blocks = SIZE_W'(MAX_FILE_BLOCKS);
            end
            else
            begin
                rq.size_blocks = SIZE_W'($urandom_range(MAX_FILE_BLOCKS));
            end
        end

        if ($urandom_range(99) < 85)
        begin
            rq.block_index = IDX_W'($urandom_range(MAX_FILE_BLOCKS));
        end
        else
        begin
            rq.block_index = IDX_W'($urandom_range(15));
        end
        return rq;
    endfunction

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------
    // Called at a rising edge, returns at the edge of acceptance. valid is
    // left high on return so that back-to-back transactions never see a
    // lower-and-raise within one time step; an idle gap lowers it instead.
    task automatic offer_request(input file_req_t rq, input logic typed,
                                 input alloc_result_t want);
        alloc_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rq.req_type;
        req_ch.file_name   <= rq.file_name;
        req_ch.size_blocks <= rq.size_blocks;
        req_ch.block_index <= rq.block_index;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        // model is stepped for every row so its state tracks the block
        predicted = file_table_result(rq);
        awaited_results.push_back(typed ? want : predicted);
        req_count[rq.req_type]++;
    endtask

    // -----------------------------------------------------------------------
    // Response side: random stalls, plus one long hold-off on request
    // -----------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: each result transaction against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            status_seen[rsp_ch.status]++;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: status %0d disk_block %0d",
                         $time, rsp_ch.status, rsp_ch.disk_block);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.disk_block !== want.disk_block)
                begin
                    $display("%0t: disk_block mismatch: expected %0d, actual %0d",
                             $time, want.disk_block, rsp_ch.disk_block);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: any transaction on either side restarts the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, awaited_results.size());
        $display("FAILURE");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Directed table
    // -----------------------------------------------------------------------
    // Walks the special cases from a clean table: misses before anything
    // exists, bad sizes, a zero-size file, a full eight-block file with an
    // all-ones name, junk after a terminator, duplicate names resolving to
    // the lowest inode, block reuse after delete, and the unused request code.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        {REQ_MAP,    NAME_A,          4'd0,  4'd0,  TYPED,     ST_NOTFOUND, 7'd0},
        {REQ_DELETE, NAME_A,          4'd0,  4'd0,  TYPED,     ST_NOTFOUND, 7'd0},
        {REQ_CREATE, NAME_A,          4'd15, 4'd0,  TYPED,     ST_BADSIZE,  7'd0},
        {REQ_CREATE, NAME_A,          4'd9,  4'd0,  TYPED,     ST_BADSIZE,  7'd0},
        {REQ_CREATE, NAME_A,          4'd0,  4'd0,  TYPED,     ST_OK,       7'd0},
        {REQ_MAP,    NAME_A,          4'd0,  4'd0,  TYPED,     ST_RANGE,    7'd0},
        {REQ_CREATE, NAME_FULL,       4'd8,  4'd15, TYPED,     ST_OK,       7'd0},
        // block 0 is metadata, so the eight-block file sits in 1..8
        {REQ_MAP,    NAME_FULL,       4'd15, 4'd0,  TYPED,     ST_OK,       7'd1},
        {REQ_MAP,    NAME_FULL,       4'd0,  4'd7,  TYPED,     ST_OK,       7'd8},
        {REQ_MAP,    NAME_FULL,       4'd0,  4'd8,  TYPED,     ST_RANGE,    7'd0},
        {REQ_MAP,    NAME_FULL,       4'd0,  4'd15, TYPED,     ST_RANGE,    7'd0},
        {REQ_CREATE, NAME_B_JUNK,     4'd3,  4'd0,  TYPED,     ST_OK,       7'd0},
        {REQ_MAP,    NAME_B,          4'd0,  4'd2,  PREDICTED, ST_OK,       7'd0},
        {REQ_CREATE, NAME_B,          4'd2,  4'd0,  PREDICTED, ST_OK,       7'd0},
        {REQ_MAP,    NAME_B_JUNK,     4'd0,  4'd1,  PREDICTED, ST_OK,       7'd0},
        {REQ_DELETE, NAME_FULL,       4'd0,  4'd0,  PREDICTED, ST_OK,       7'd0},
        {REQ_CREATE, NAME_EMPTY_JUNK, 4'd4,  4'd0,  PREDICTED, ST_OK,       7'd0},
        {REQ_MAP,    NAME_EMPTY,      4'd0,  4'd3,  PREDICTED, ST_OK,       7'd0},
        {REQ_DELETE, NAME_B,          4'd0,  4'd0,  PREDICTED, ST_OK,       7'd0},
        {REQ_MAP,    NAME_B,          4'd0,  4'd1,  PREDICTED, ST_OK,       7'd0},
        {REQ_MAP,    NAME_B,          4'd0,  4'd2,  PREDICTED, ST_OK,       7'd0},
        {REQ_NOP,    NAME_FULL,       4'd15, 4'd15, TYPED,     ST_OK,       7'd0},
        {REQ_NOP,    NAME_EMPTY,      4'd0,  4'd0,  TYPED,     ST_OK,       7'd0},
        {REQ_DELETE, NAME_A,          4'd0,  4'd0,  PREDICTED, ST_OK,       7'd0},
        {REQ_MAP,    NAME_A,          4'd0,  4'd0,  TYPED,     ST_NOTFOUND, 7'd0}
    };

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        file_req_t    rq;
        traffic_mix_e mix;
        int           ph;
        int           n;
        int           k;
        int           b;
        int           burst;
        int           counted;

        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_NOP;
        req_ch.file_name   <= '0;
        req_ch.size_blocks <= '0;
        req_ch.block_index <= '0;

        // model reset state: only the metadata block is taken
        for (n = 0; n < NUM_BLOCKS; n++)
        begin
            disk_used[n] = (n == 0);
        end
        for (n = 0; n < NUM_ENTRIES; n++)
        begin
            inode_live[n] = 1'b0;
        end
        for (n = 0; n < 4; n++)
        begin
            req_count[n] = 0;
        end
        for (n = 0; n < 8; n++)
        begin
            status_seen[n] = 0;
        end

        // name pool: lengths 0..8, non-zero bytes up to the length
        for (k = 0; k < NAME_POOL; k++)
        begin
            name_len[k]  = k % (NAME_BYTES + 1);
            name_pool[k] = '0;
            for (b = 0; b < name_len[k]; b++)
            begin
                name_pool[k][8*b +: 8] = 8'($urandom_range(255, 1));
            end
        end

        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end

        // The block sweeps its map after reset; the first transaction simply
        // waits on ready.
        for (n = 0; n < DIRECTED_ROWS; n++)
        begin
            offer_request(directed_rows[n].rq, directed_rows[n].typed,
                          directed_rows[n].want);
        end

        // Random traffic in four idle/stall mixes. Bursts of one traffic mix
        // at a time so the table really fills up and drains again.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 81; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase

            // Output held off for a long stretch while requests keep
            // coming: the result register fills and the input must stall.
            if (ph == 0)
            begin
                hold_pending = 1'b1;
                for (n = 0; n < PRESSURE_ITEMS; n++)
                begin
                    offer_request(random_request(MIX_CHURN), PREDICTED, '0);
                end
            end

            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                mix   = traffic_mix_e'($urandom_range(2));
                burst = $urandom_range(60, 20);
                for (n = 0; n < burst && counted < PHASE_ITEMS; n++)
                begin
                    rq = random_request(mix);
                    offer_request(rq, PREDICTED, '0);
                    if (rq.req_type != REQ_NOP)
                    begin
                        counted++;
                    end
                end
            end
        end

        req_ch.valid <= 1'b0;
        stall_pct     = 0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d create, %0d delete, %0d map, %0d unused code;",
                 req_count[0] + req_count[1] + req_count[2] + req_count[3],
                 req_count[0], req_count[1], req_count[2], req_count[3]);
        $display("status ok %0d, bad size %0d, no space %0d, no inode %0d, %s %0d, %s %0d",
                 status_seen[ST_OK], status_seen[ST_BADSIZE], status_seen[ST_NOSPACE],
                 status_seen[ST_NOINODE], "not found", status_seen[ST_NOTFOUND],
                 "out of range", status_seen[ST_RANGE]);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
